// ===== design/cse_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cse_pkg
// Shared constants and types of the COBS stream encoder.
// ----------------------------------------------------------------------------
package cse_pkg;

    // Longest run that the run memory holds before it closes with code 0xFF.
    localparam int MAX_RUN        = 254;
    localparam int LEN_W          = 8;
    localparam int ADDR_W         = 8;
    // Lanes in a result word and the width of a lane counter (up to eight lanes).
    localparam int MAX_LANES      = 8;
    localparam int LANE_W         = 3;
    localparam int WORD_W         = 64;
    localparam int CNT_W          = 4;
    localparam int DEF_BYTES_PER_WORD = 8;

    localparam logic [7:0] ZERO_BYTE  = 8'h00;
    localparam logic [7:0] CODE_EMPTY = 8'h01;

    // One encoded byte handed from the sequencer to the packer.
    typedef struct packed {
        logic       valid;
        logic       from_mem;   // byte comes from the run memory read port
        logic [7:0] code;       // code byte when not from memory
        logic       last;       // final byte of this burst
        logic       eom;        // burst closes the message
    } t_byte_req;

endpackage : cse_pkg
`default_nettype wire

// ===== design/cse_run_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cse_run_mem
// Run buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cse_run_mem
    import cse_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [7:0]        i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [7:0]        o_rd_data
);

    logic [7:0] r_mem [MAX_RUN];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds between reads, so a byte waiting in the packer stays put.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule : cse_run_mem
`default_nettype wire

// ===== design/cse_packer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cse_packer
// Byte stage and word packer: gathers encoded bytes into result words and
// holds the output register of the result channel.
// ----------------------------------------------------------------------------
module cse_packer
    import cse_pkg::*;
#(
    parameter int BYTES_PER_WORD = DEF_BYTES_PER_WORD
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_byte_req         i_req,
    output logic                   o_take,
    input  wire logic [7:0]        i_mem_data,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic      [WORD_W-1:0] o_out_word,
    output logic      [CNT_W-1:0]  o_byte_count,
    output logic                   o_message_done,
    output logic                   o_burst_last
);

    localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(BYTES_PER_WORD - 1);

    t_byte_req         r_b;
    logic [WORD_W-1:0] r_word;
    logic [LANE_W-1:0] r_n;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_word;
    logic [CNT_W-1:0]  r_out_cnt;
    logic              r_out_done;
    logic              r_out_last;

    logic [7:0]        cur_byte;
    logic              word_done;
    logic              out_free;
    logic              consume;
    logic [WORD_W-1:0] n_word;

    assign cur_byte  = r_b.from_mem ? i_mem_data : r_b.code;
    assign word_done = r_b.last || (r_n == LAST_LANE);
    assign out_free  = !r_out_valid || !i_stall;
    assign consume   = r_b.valid && (!word_done || out_free);
    assign o_take    = !r_b.valid || consume;
    assign n_word    = r_word | (WORD_W'(cur_byte) << {r_n, 3'b000});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b         <= '0;
            r_word      <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_b <= i_req;
            end
            if (consume) begin
                if (word_done) begin
                    r_word <= '0;
                    r_n    <= '0;
                end else begin
                    r_word <= n_word;
                    r_n    <= r_n + LANE_W'(1);
                end
            end
            if (consume && word_done) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && word_done) begin
            r_out_word <= n_word;
            r_out_cnt  <= CNT_W'(r_n) + CNT_W'(1);
            r_out_done <= r_b.last && r_b.eom;
            r_out_last <= r_b.last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_word     = r_out_word;
    assign o_byte_count   = r_out_cnt;
    assign o_message_done = r_out_done;
    assign o_burst_last   = r_out_last;

endmodule : cse_packer
`default_nettype wire

// ===== design/cobs_stream_encoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cobs_stream_encoder
// COBS encoder for a byte stream, result bytes packed into words.
// ----------------------------------------------------------------------------
// A byte that neither closes a run nor ends the message is written to the run
// memory and the block takes the next beat in the following cycle. A beat
// that closes a run of L bytes (a zero byte, the 254th byte of a run, or the
// end of the message) starts a burst of L+1 encoded bytes, plus one more code
// byte 0x01 when a beat that closes with a zero or a full run also ends the
// message. The sequencer sends one byte per cycle, while the packer takes it,
// through the single read port of the run memory, so the input stalls until
// every burst byte is handed on, and longer while the result side stalls.
// Burst bytes leave as words of BYTES_PER_WORD bytes, and the final word of a
// burst may be partial.
// ----------------------------------------------------------------------------
module cobs_stream_encoder
    import cse_pkg::*;
#(
    parameter int BYTES_PER_WORD = DEF_BYTES_PER_WORD
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_end_of_message,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic      [WORD_W-1:0] o_out_word,
    output logic      [CNT_W-1:0]  o_byte_count,
    output logic                   o_message_done,
    output logic                   o_burst_last
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CODE1 = 4'b0010,
        S_RUN   = 4'b0100,
        S_CODE2 = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_close, n_close;
    logic [LEN_W-1:0] r_idx, n_idx;
    logic             r_second, n_second;
    logic             r_eom, n_eom;

    logic             accept;
    logic             is_zero;
    logic [LEN_W-1:0] len_inc;
    logic             is_full;
    logic             start;
    logic             take;
    logic             run_end;
    t_byte_req        req;
    logic [7:0]       mem_rd_data;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;
    assign is_zero = (i_data_byte == ZERO_BYTE);
    assign len_inc = r_len + LEN_W'(1);
    assign is_full = !is_zero && (len_inc == LEN_W'(MAX_RUN));
    assign start   = accept && (is_zero || is_full || i_end_of_message);
    assign run_end = (r_idx == r_close - LEN_W'(1));

    // The byte is written at the accepting edge; reads of the run begin no
    // earlier than the next cycle, so they always see it.
    cse_run_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (accept && !is_zero),
        .i_wr_addr (r_len),
        .i_wr_data (i_data_byte),
        .i_rd_en   (req.valid && req.from_mem),
        .i_rd_addr (r_idx),
        .o_rd_data (mem_rd_data)
    );

    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_close  = r_close;
        n_idx    = r_idx;
        n_second = r_second;
        n_eom    = r_eom;
        req      = '0;
        req.eom  = r_eom;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_len = start ? '0 : len_inc;
                end
                if (start) begin
                    n_state  = S_CODE1;
                    n_close  = is_zero ? r_len : len_inc;
                    n_second = (is_zero || is_full) && i_end_of_message;
                    n_eom    = i_end_of_message;
                    n_idx    = '0;
                end
            end
            S_CODE1: begin
                req.valid = take;
                req.code  = r_close + LEN_W'(1);
                req.last  = !r_second && (r_close == '0);
                if (take) begin
                    if (r_close != '0) begin
                        n_state = S_RUN;
                    end else if (r_second) begin
                        n_state = S_CODE2;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_RUN: begin
                req.valid    = take;
                req.from_mem = 1'b1;
                req.last     = !r_second && run_end;
                if (take) begin
                    if (run_end) begin
                        n_state = r_second ? S_CODE2 : S_IDLE;
                    end else begin
                        n_idx = r_idx + LEN_W'(1);
                    end
                end
            end
            S_CODE2: begin
                req.valid = take;
                req.code  = CODE_EMPTY;
                req.last  = 1'b1;
                if (take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_close  <= n_close;
        r_idx    <= n_idx;
        r_second <= n_second;
        r_eom    <= n_eom;
    end

    cse_packer #(
        .BYTES_PER_WORD (BYTES_PER_WORD)
    ) u_packer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (req),
        .o_take         (take),
        .i_mem_data     (mem_rd_data),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_word     (o_out_word),
        .o_byte_count   (o_byte_count),
        .o_message_done (o_message_done),
        .o_burst_last   (o_burst_last)
    );

endmodule : cobs_stream_encoder
`default_nettype wire
